// File: rtl/salc_pkg.sv
package salc_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_UPDATE
    } salc_state_t;

    localparam logic [1:0] ACT_ILOAD = 2'd0;
    localparam logic [1:0] ACT_DLOAD = 2'd1;
    localparam logic [1:0] ACT_STORE = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [2:0] REG_SPLIT  = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_DSETS  = 3'd2;
    localparam logic [2:0] REG_ISETS  = 3'd3;
    localparam logic [2:0] REG_WAYS   = 3'd4;
    localparam logic [2:0] REG_WBACK  = 3'd5;
    localparam logic [2:0] REG_WALLOC = 3'd6;

    localparam int CFG_W  = 4;
    localparam int CNT7_W = 7;

    // result of one pass of the way scan
    typedef struct packed {
        logic hit;
        logic free;
    } scan_flags_t;

endpackage

// File: rtl/salc_store.sv
module salc_store #(
    parameter int ROW_W   = 9,
    parameter int MAX_WAYS = 8,
    parameter int TAG_W   = 30,
    parameter int MW      = 5
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [ROW_W-1:0]                  rd_addr,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]    tag_q,
    output logic [MAX_WAYS-1:0][MW-1:0]       meta_q,
    input  logic                              tag_we,
    input  logic                              meta_we,
    input  logic [ROW_W-1:0]                  wr_addr,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]    wr_tag,
    input  logic [MAX_WAYS-1:0][MW-1:0]       wr_meta
);
    localparam int ROWS = 2 ** ROW_W;

    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem  [ROWS];
    logic [MAX_WAYS-1:0][MW-1:0]    meta_mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (meta_we)
        begin
            meta_mem[wr_addr] <= wr_meta;
        end
        if (rd_en)
        begin
            tag_q  <= tag_mem[rd_addr];
            meta_q <= meta_mem[rd_addr];
        end
    end

endmodule

// File: rtl/salc_scan.sv
module salc_scan #(
    parameter int WAY_W = 3,
    parameter int TAG_W = 30,
    parameter int RW    = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  logic [WAY_W-1:0]     idx,
    input  logic                 line_valid,
    input  logic [TAG_W-1:0]     line_tag,
    input  logic [RW-1:0]        line_rank,
    input  logic [TAG_W-1:0]     ref_tag,
    output salc_pkg::scan_flags_t flags,
    output logic [WAY_W-1:0]     hit_way,
    output logic [WAY_W-1:0]     free_way,
    output logic [WAY_W-1:0]     worst_way
);
    import salc_pkg::*;

    scan_flags_t      flags_reg, flags_next;
    logic [WAY_W-1:0] hit_way_reg, hit_way_next;
    logic [WAY_W-1:0] free_way_reg, free_way_next;
    logic [WAY_W-1:0] worst_way_reg, worst_way_next;
    logic [RW-1:0]    worst_rank_reg, worst_rank_next;
    logic             tag_eq;

    // the single shared tag comparator
    assign tag_eq = (line_tag == ref_tag);

    always_comb
    begin
        flags_next      = flags_reg;
        hit_way_next    = hit_way_reg;
        free_way_next   = free_way_reg;
        worst_way_next  = worst_way_reg;
        worst_rank_next = worst_rank_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else if (step)
        begin
            if (!flags_reg.hit && line_valid && tag_eq)
            begin
                flags_next.hit = 1'b1;
                hit_way_next   = idx;
            end
            if (!flags_reg.free && !line_valid)
            begin
                flags_next.free = 1'b1;
                free_way_next   = idx;
            end
            // highest rank, lowest way on a tie
            if (idx == '0 || line_rank > worst_rank_reg)
            begin
                worst_way_next  = idx;
                worst_rank_next = line_rank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_way_reg    <= hit_way_next;
        free_way_reg   <= free_way_next;
        worst_way_reg  <= worst_way_next;
        worst_rank_reg <= worst_rank_next;
    end

    assign flags     = flags_reg;
    assign hit_way   = hit_way_reg;
    assign free_way  = free_way_reg;
    assign worst_way = worst_way_reg;

endmodule

// File: rtl/set_assoc_lru_cache_tags.sv
// channel | dir | beat content
// s_*     | in  | s_tdata: address ; s_tuser: action
// m_*     | out | m_tdata: hit, replaced, fetch_words, copy_back_words
// cfg_*   | in  | cfg_index: register number ; cfg_data: register value
//
// an access runs a decode step with the set row read, a scan of the ways in
// turn through the shared tag comparator, an update step; a no-op skips to update
// reset starts a clearing pass over the 2 * 2^MAX_SET_BITS line
// state rows (valid, dirty, lru rank); s_tready stays low until it ends
// a finished result sits in the output register, the next beat is taken
// meanwhile; the update cycle waits while that register is still full
module set_assoc_lru_cache_tags #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((ADDR_BITS+7)/8)*8-1:0]    s_tdata,  // address
    input  logic [1:0]                        s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit, replaced, fetch_words[6:0], copy_back_words[6:0]
    output logic [15:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [salc_pkg::CFG_W-1:0]        cfg_data
);
    import salc_pkg::*;

    localparam int TAG_W = ADDR_BITS - 2;
    localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W = $clog2(MAX_WAYS + 1);
    localparam int ROW_W = MAX_SET_BITS + 1;
    localparam int MW    = RW + 2;
    localparam int V_BIT = MW - 1;
    localparam int D_BIT = MW - 2;

    // configuration registers
    logic             split_reg;
    logic [CFG_W-1:0] off_cfg_reg, dsb_reg, isb_reg, ways_reg;
    logic             wback_reg, walloc_reg;

    salc_state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [1:0]           action_reg;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [ROW_W-1:0]     clr_reg, clr_next;
    logic [WAY_W-1:0]     way_reg, way_next;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;

    // geometry after clamping
    logic [CFG_W-1:0] off;
    logic [CFG_W-1:0] sb_raw, sb;
    logic [CNT_W-1:0] nways;
    logic [CNT7_W-1:0] words;
    logic             use_inst;
    logic [ADDR_BITS-1:0] shifted, set_mask;
    logic [MAX_SET_BITS-1:0] set_idx;

    // store
    logic                           rd_en, tag_we, meta_we;
    logic [ROW_W-1:0]               wr_addr;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_q, wr_tag;
    logic [MAX_WAYS-1:0][MW-1:0]    meta_q, wr_meta;

    // scan
    scan_flags_t      flags;
    logic [WAY_W-1:0] hit_way, free_way, worst_way;
    logic             scan_start, scan_step;

    // update
    logic             store, is_nop, no_alloc, fill;
    logic [WAY_W-1:0] tgt;
    logic [RW-1:0]    old_rank;
    logic             age_all;
    logic [CNT7_W-1:0] copy_words;
    logic [MAX_WAYS-1:0][MW-1:0] meta_upd;
    logic             out_free;
    logic             in_acc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg   <= 1'b0;
            off_cfg_reg <= CFG_W'(4);
            dsb_reg     <= CFG_W'(6);
            isb_reg     <= CFG_W'(6);
            ways_reg    <= CFG_W'(1);
            wback_reg   <= 1'b1;
            walloc_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPLIT:  split_reg   <= cfg_data[0];
                REG_OFFSET: off_cfg_reg <= cfg_data;
                REG_DSETS:  dsb_reg     <= cfg_data;
                REG_ISETS:  isb_reg     <= cfg_data;
                REG_WAYS:   ways_reg    <= cfg_data;
                REG_WBACK:  wback_reg   <= cfg_data[0];
                REG_WALLOC: walloc_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp block offset to 2..8, ways to 1..MAX_WAYS, set bits to MAX_SET_BITS
    always_comb
    begin
        if (off_cfg_reg < CFG_W'(2))
        begin
            off = CFG_W'(2);
        end
        else if (off_cfg_reg > CFG_W'(8))
        begin
            off = CFG_W'(8);
        end
        else
        begin
            off = off_cfg_reg;
        end
        if (ways_reg == '0)
        begin
            nways = CNT_W'(1);
        end
        else if ({1'b0, ways_reg} > 5'(MAX_WAYS))
        begin
            nways = CNT_W'(MAX_WAYS);
        end
        else
        begin
            nways = CNT_W'(ways_reg);
        end
    end

    assign words    = CNT7_W'(1) << (off - CFG_W'(2));
    assign use_inst = split_reg && (action_reg == ACT_ILOAD);
    assign sb_raw   = use_inst ? isb_reg : dsb_reg;
    assign sb       = ({1'b0, sb_raw} > 5'(MAX_SET_BITS)) ? CFG_W'(MAX_SET_BITS) : sb_raw;
    assign shifted  = addr_reg >> off;
    assign set_mask = ~({ADDR_BITS{1'b1}} << sb);
    assign set_idx  = MAX_SET_BITS'(shifted & set_mask);

    assign store    = (action_reg == ACT_STORE);
    assign is_nop   = (action_reg == ACT_NONE);
    assign no_alloc = !flags.hit && store && !walloc_reg;
    assign fill     = !flags.hit && !no_alloc;
    assign out_free = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // target way: hit way, else lowest free way, else the lru victim
    always_comb
    begin
        if (flags.hit)
        begin
            tgt = hit_way;
        end
        else if (flags.free)
        begin
            tgt = free_way;
        end
        else
        begin
            tgt = worst_way;
        end
    end

    assign old_rank = meta_q[tgt][RW-1:0];
    assign age_all  = !flags.hit && flags.free;

    // new line state of the row, lanes age against the target's old rank
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            meta_upd[i] = meta_q[i];
            if (WAY_W'(i) == tgt)
            begin
                meta_upd[i][V_BIT]    = 1'b1;
                meta_upd[i][RW-1:0]   = '0;
                if (flags.hit)
                begin
                    if (store)
                    begin
                        meta_upd[i][D_BIT] = wback_reg;
                    end
                end
                else
                begin
                    meta_upd[i][D_BIT] = store && wback_reg;
                end
            end
            else if (CNT_W'(i) < nways && meta_q[i][V_BIT]
                     && (age_all || meta_q[i][RW-1:0] < old_rank)
                     && meta_q[i][RW-1:0] != RW'(MAX_WAYS - 1))
            begin
                meta_upd[i][RW-1:0] = meta_q[i][RW-1:0] + RW'(1);
            end
        end
        wr_tag      = tag_q;
        wr_tag[tgt] = tag_reg;
    end

    // words written back for this access
    always_comb
    begin
        copy_words = '0;
        if (flags.hit)
        begin
            copy_words = (store && !wback_reg) ? CNT7_W'(1) : '0;
        end
        else if (no_alloc)
        begin
            copy_words = CNT7_W'(1);
        end
        else
        begin
            if (!flags.free && meta_q[tgt][D_BIT])
            begin
                copy_words = words;
            end
            if (store && !wback_reg)
            begin
                copy_words = copy_words + CNT7_W'(1);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        tag_next     = tag_reg;
        row_next     = row_reg;
        clr_next     = clr_reg;
        way_next     = way_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        tag_we       = 1'b0;
        meta_we      = 1'b0;
        wr_addr      = row_reg;
        wr_meta      = meta_upd;
        scan_start   = 1'b0;
        scan_step    = 1'b0;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                meta_we  = 1'b1;
                wr_addr  = clr_reg;
                wr_meta  = '0;
                clr_next = clr_reg + ROW_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (s_tuser == ACT_NONE) ? ST_UPDATE : ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                tag_next   = TAG_W'(addr_reg >> (5'(off) + 5'(sb)));
                row_next   = {use_inst, set_idx};
                rd_en      = 1'b1;
                scan_start = 1'b1;
                way_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                way_next  = way_reg + WAY_W'(1);
                if (CNT_W'(way_reg) + CNT_W'(1) == nways)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (is_nop)
                    begin
                        m_data_next = '0;
                    end
                    else
                    begin
                        meta_we     = !no_alloc;
                        tag_we      = fill;
                        m_data_next = {copy_words, (fill ? words : CNT7_W'(0)),
                                       fill && !flags.free, flags.hit};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            way_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            way_reg     <= way_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            addr_reg   <= ADDR_BITS'(s_tdata);
            action_reg <= s_tuser;
        end
        tag_reg    <= tag_next;
        row_reg    <= row_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    salc_store #(
        .ROW_W   (ROW_W),
        .MAX_WAYS(MAX_WAYS),
        .TAG_W   (TAG_W),
        .MW      (MW)
    ) u_store (
        .clk    (clk),
        .rd_en  (rd_en),
        .rd_addr(row_next),
        .tag_q  (tag_q),
        .meta_q (meta_q),
        .tag_we (tag_we),
        .meta_we(meta_we),
        .wr_addr(wr_addr),
        .wr_tag (wr_tag),
        .wr_meta(wr_meta)
    );

    salc_scan #(
        .WAY_W(WAY_W),
        .TAG_W(TAG_W),
        .RW   (RW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .step      (scan_step),
        .idx       (way_reg),
        .line_valid(meta_q[way_reg][V_BIT]),
        .line_tag  (tag_q[way_reg]),
        .line_rank (meta_q[way_reg][RW-1:0]),
        .ref_tag   (tag_reg),
        .flags     (flags),
        .hit_way   (hit_way),
        .free_way  (free_way),
        .worst_way (worst_way)
    );

endmodule

// File: rtl/salc_chk.sv
module salc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("hit with fill or replacement");

    a_replace_fills: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> !m_tdata[0] && m_tdata[8:2] != 7'd0)
        else $error("replacement without block fill");

    a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:9] <= 7'd65)
        else $error("copy back count out of range");

endmodule

bind set_assoc_lru_cache_tags salc_chk u_salc_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
